@@ sv/grld_pkg.sv @@
`default_nettype none
package grld_pkg;

  // grid geometry
  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int ROW_W    = 7;
  localparam int COL_W    = 7;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CNT_W    = ADDR_W + 1;
  localparam int DIM_W    = 8;
  localparam int VAL_W    = 8;
  localparam int LABEL_W  = 13;
  localparam int DIST_W   = 7;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam logic [DIM_W-1:0]  DIM_MAX_ROWS   = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0]  DIM_MAX_COLS   = DIM_W'(MAX_COLS);
  localparam logic [VAL_W-1:0]  OBSTACLE_LIMIT = 8'd128;
  localparam logic [DIST_W-1:0] DIST_SAT       = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  QUEUE_DEPTH    = CNT_W'(CELLS);

  // command codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic                occ;
    logic                reached;
    logic [DIST_W-1:0]   distance;
    logic [LABEL_W-1:0]  label;
  } cell_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  val;
  } req_t;

  typedef struct packed {
    logic                kind;
    logic [LABEL_W-1:0]  count;
    logic [DIST_W-1:0]   distance;
    logic                unreached;
    logic [LABEL_W-1:0]  label;
  } res_t;

  // neighbour row offset, order (-1,-1) (-1,0) (-1,+1) (0,-1) (0,+1) (+1,-1) (+1,0) (+1,+1)
  function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
    logic signed [1:0] d;
    d = 2'sd0;
    case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd5, 3'd6, 3'd7: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  // neighbour column offset
  function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
    logic signed [1:0] d;
    d = 2'sd0;
    case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd2, 3'd4, 3'd7: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  // zero acts as one, too large acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/grid_region_label_distance_unit.sv @@
// Obstacle region labelling and chessboard distance walk over a stored grid.
// Input channel s_axis_*: tuser carries the command (write cell, run, read
// cell); tdata carries row, col and the grey value. Output channel m_axis_*:
// tuser is the result kind, tdata the region count, distance, unreached flag
// and region label. Registers grid_rows (index 0) and grid_cols (index 1) are
// written through cfg_we_i; the user must write them only while the block is
// idle, which the block itself does not enforce. A cell write holds the input
// through its accept, memory read and write-back states, since occupancy shares
// a memory word with the results. A read holds it through its memory read,
// evaluation and result states; its result passes through the engine result
// register and the output register to m_axis. A run does a clearing sweep, a
// labelling scan with a queued flood fill per new region, a seeding pass and
// the walk, one cell access a step; off-grid neighbours are skipped.
// After reset no run has happened: reads answer unreached, count 0; cell
// contents are undefined until written. A result waits in the output register
// while the receiver stalls; further cell writes are still accepted meanwhile,
// and the input stalls once a second result is waiting behind it.
`default_nettype none
module grid_region_label_distance_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // row[6:0], col[13:7], cell_value[21:14], zero
  input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // region_count[12:0], distance[19:13],
                                           // unreached[20], region_label[33:21], zero
  output logic [0:0]       m_axis_tuser,   // result_kind[0]
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic [grld_pkg::DIM_W-1:0] rows_q, cols_q;
  grld_pkg::req_t req;
  grld_pkg::res_t res;
  logic res_valid, res_ready;
  logic out_valid_q;
  grld_pkg::res_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= grld_pkg::DIM_W'(128);
      cols_q <= grld_pkg::DIM_W'(128);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == grld_pkg::REG_ROWS) rows_q <= cfg_data_i;
      if (cfg_idx_i == grld_pkg::REG_COLS) cols_q <= cfg_data_i;
    end
  end

  // unpack the input item
  assign req.op  = s_axis_tuser;
  assign req.row = s_axis_tdata[6:0];
  assign req.col = s_axis_tdata[13:7];
  assign req.val = s_axis_tdata[21:14];

  grld_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .grid_rows_i (rows_q),
    .grid_cols_i (cols_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'b0, out_q.label, out_q.unreached, out_q.distance, out_q.count};

endmodule
`default_nettype wire

@@ sv/grld_ram.sv @@
`default_nettype none
module grld_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [(1 << AW)];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ sv/grld_engine.sv @@
`default_nettype none
module grld_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  input  wire grld_pkg::req_t                req_i,
  output logic                               req_ready_o,
  input  wire logic [grld_pkg::DIM_W-1:0]    grid_rows_i,
  input  wire logic [grld_pkg::DIM_W-1:0]    grid_cols_i,
  output logic                               res_valid_o,
  output grld_pkg::res_t                     res_o,
  input  wire logic                          res_ready_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_WR_RD  = 5'd1;
  localparam logic [4:0] S_WR_WB  = 5'd2;
  localparam logic [4:0] S_RD_RD  = 5'd3;
  localparam logic [4:0] S_RD_EV  = 5'd4;
  localparam logic [4:0] S_OUT    = 5'd5;
  localparam logic [4:0] S_CLR_RD = 5'd6;
  localparam logic [4:0] S_CLR_WB = 5'd7;
  localparam logic [4:0] S_LS_RD  = 5'd8;
  localparam logic [4:0] S_LS_EV  = 5'd9;
  localparam logic [4:0] S_LF_POP = 5'd10;
  localparam logic [4:0] S_LF_CUR = 5'd11;
  localparam logic [4:0] S_LF_NRD = 5'd12;
  localparam logic [4:0] S_LF_NEV = 5'd13;
  localparam logic [4:0] S_SD_RD  = 5'd14;
  localparam logic [4:0] S_SD_EV  = 5'd15;
  localparam logic [4:0] S_WK_POP = 5'd16;
  localparam logic [4:0] S_WK_CUR = 5'd17;
  localparam logic [4:0] S_WK_CV  = 5'd18;
  localparam logic [4:0] S_WK_NRD = 5'd19;
  localparam logic [4:0] S_WK_NEV = 5'd20;

  logic [4:0] state_q, state_d;
  grld_pkg::req_t req_q, req_d;
  logic [grld_pkg::ROW_W-1:0] r_q, r_d, cur_r_q, cur_r_d;
  logic [grld_pkg::COL_W-1:0] c_q, c_d, cur_c_q, cur_c_d;
  logic [2:0] k_q, k_d;
  logic [grld_pkg::CNT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [grld_pkg::LABEL_W-1:0] regions_q, regions_d, lab_q, lab_d;
  logic [grld_pkg::DIST_W-1:0] dist_q, dist_d;
  logic [grld_pkg::DIM_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [grld_pkg::DIM_W-1:0] run_rows_q, run_rows_d, run_cols_q, run_cols_d;
  grld_pkg::res_t res_q, res_d;

  // memory ports
  logic cell_we, cell_re, q_we, q_re;
  logic [grld_pkg::ADDR_W-1:0] cell_waddr, cell_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  grld_pkg::cell_t cell_wdata, cell_rdata;

  grld_ram #(.WIDTH($bits(grld_pkg::cell_t)), .AW(grld_pkg::ADDR_W)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  grld_ram #(.WIDTH(grld_pkg::ADDR_W), .AW(grld_pkg::ADDR_W)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // neighbour of the current cell
  logic signed [1:0] dr, dc;
  logic [8:0] nr9, nc9;
  logic nb_ok;
  logic [grld_pkg::ADDR_W-1:0] nb_addr, scan_addr;
  logic last_col, last_row, q_room;

  assign dr = grld_pkg::nb_dr(k_q);
  assign dc = grld_pkg::nb_dc(k_q);
  assign nr9 = {2'b00, cur_r_q} + {{7{dr[1]}}, dr};
  assign nc9 = {2'b00, cur_c_q} + {{7{dc[1]}}, dc};
  assign nb_ok = !nr9[8] && !nc9[8] && (nr9[7:0] < rows_q) && (nc9[7:0] < cols_q);
  assign nb_addr = {nr9[grld_pkg::ROW_W-1:0], nc9[grld_pkg::COL_W-1:0]};
  assign scan_addr = {r_q, c_q};
  assign last_col = ({1'b0, c_q} == cols_q - grld_pkg::DIM_W'(1));
  assign last_row = ({1'b0, r_q} == rows_q - grld_pkg::DIM_W'(1));
  assign q_room = (tail_q < grld_pkg::QUEUE_DEPTH);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o = res_q;

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    r_d = r_q;
    c_d = c_q;
    cur_r_d = cur_r_q;
    cur_c_d = cur_c_q;
    k_d = k_q;
    head_d = head_q;
    tail_d = tail_q;
    regions_d = regions_q;
    lab_d = lab_q;
    dist_d = dist_q;
    rows_d = rows_q;
    cols_d = cols_q;
    run_rows_d = run_rows_q;
    run_cols_d = run_cols_q;
    res_d = res_q;
    cell_we = 1'b0;
    cell_re = 1'b0;
    cell_waddr = scan_addr;
    cell_raddr = scan_addr;
    cell_wdata = cell_rdata;
    q_we = 1'b0;
    q_re = 1'b0;
    q_waddr = tail_q[grld_pkg::ADDR_W-1:0];
    q_raddr = head_q[grld_pkg::ADDR_W-1:0];
    q_wdata = nb_addr;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          unique case (req_i.op)
            grld_pkg::OP_WRITE: state_d = S_WR_RD;
            grld_pkg::OP_READ:  state_d = S_RD_RD;
            grld_pkg::OP_RUN: begin
              rows_d = grld_pkg::clamp_dim(grid_rows_i, grld_pkg::DIM_MAX_ROWS);
              cols_d = grld_pkg::clamp_dim(grid_cols_i, grld_pkg::DIM_MAX_COLS);
              r_d = '0;
              c_d = '0;
              state_d = S_CLR_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // occupancy write keeps the stored results
      S_WR_RD: begin
        cell_re = 1'b1;
        cell_raddr = {req_q.row, req_q.col};
        state_d = S_WR_WB;
      end
      S_WR_WB: begin
        cell_we = 1'b1;
        cell_waddr = {req_q.row, req_q.col};
        cell_wdata.occ = (req_q.val < grld_pkg::OBSTACLE_LIMIT);
        state_d = S_IDLE;
      end
      // cell read
      S_RD_RD: begin
        cell_re = 1'b1;
        cell_raddr = {req_q.row, req_q.col};
        state_d = S_RD_EV;
      end
      S_RD_EV: begin
        res_d.kind = grld_pkg::KIND_READ;
        res_d.count = regions_q;
        if (({1'b0, req_q.row} < run_rows_q) && ({1'b0, req_q.col} < run_cols_q) &&
            cell_rdata.reached) begin
          res_d.distance = cell_rdata.distance;
          res_d.unreached = 1'b0;
          res_d.label = cell_rdata.label;
        end else begin
          res_d.distance = '0;
          res_d.unreached = 1'b1;
          res_d.label = '0;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      // clearing sweep over the grid in use
      S_CLR_RD: begin
        cell_re = 1'b1;
        state_d = S_CLR_WB;
      end
      S_CLR_WB: begin
        cell_we = 1'b1;
        cell_wdata = '0;
        cell_wdata.occ = cell_rdata.occ;
        state_d = S_CLR_RD;
        if (last_col) begin
          c_d = '0;
          if (last_row) begin
            r_d = '0;
            regions_d = '0;
            state_d = S_LS_RD;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      // labelling scan
      S_LS_RD: begin
        cell_re = 1'b1;
        state_d = S_LS_EV;
      end
      S_LS_EV: begin
        if (cell_rdata.occ && cell_rdata.label == '0) begin
          regions_d = regions_q + 1'b1;
          lab_d = regions_q + 1'b1;
          cell_we = 1'b1;
          cell_wdata.label = regions_q + 1'b1;
          q_we = 1'b1;
          q_waddr = '0;
          q_wdata = scan_addr;
          head_d = '0;
          tail_d = grld_pkg::CNT_W'(1);
          state_d = S_LF_POP;
        end else begin
          state_d = S_LS_RD;
          if (last_col) begin
            c_d = '0;
            if (last_row) begin
              r_d = '0;
              head_d = '0;
              tail_d = '0;
              state_d = S_SD_RD;
            end else begin
              r_d = r_q + 1'b1;
            end
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
      // region flood fill
      S_LF_POP: begin
        if (head_q < tail_q) begin
          q_re = 1'b1;
          head_d = head_q + 1'b1;
          state_d = S_LF_CUR;
        end else begin
          state_d = S_LS_RD;
          if (last_col) begin
            c_d = '0;
            if (last_row) begin
              r_d = '0;
              head_d = '0;
              tail_d = '0;
              state_d = S_SD_RD;
            end else begin
              r_d = r_q + 1'b1;
            end
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
      S_LF_CUR: begin
        cur_r_d = q_rdata[grld_pkg::ADDR_W-1:grld_pkg::COL_W];
        cur_c_d = q_rdata[grld_pkg::COL_W-1:0];
        k_d = '0;
        state_d = S_LF_NRD;
      end
      S_LF_NRD: begin
        if (nb_ok) begin
          cell_re = 1'b1;
          cell_raddr = nb_addr;
          state_d = S_LF_NEV;
        end else if (k_q == 3'd7) begin
          state_d = S_LF_POP;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_LF_NEV: begin
        if (cell_rdata.occ && cell_rdata.label != lab_q) begin
          cell_we = 1'b1;
          cell_waddr = nb_addr;
          cell_wdata.label = lab_q;
          if (q_room) begin
            q_we = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        if (k_q == 3'd7) begin
          state_d = S_LF_POP;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_LF_NRD;
        end
      end
      // seed the walk with every obstacle cell in raster order
      S_SD_RD: begin
        cell_re = 1'b1;
        state_d = S_SD_EV;
      end
      S_SD_EV: begin
        if (cell_rdata.occ) begin
          cell_we = 1'b1;
          cell_wdata.reached = 1'b1;
          if (q_room) begin
            q_we = 1'b1;
            q_wdata = scan_addr;
            tail_d = tail_q + 1'b1;
          end
        end
        state_d = S_SD_RD;
        if (last_col) begin
          c_d = '0;
          if (last_row) begin
            r_d = '0;
            state_d = S_WK_POP;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      // breadth-first distance walk
      S_WK_POP: begin
        if (head_q < tail_q) begin
          q_re = 1'b1;
          head_d = head_q + 1'b1;
          state_d = S_WK_CUR;
        end else begin
          run_rows_d = rows_q;
          run_cols_d = cols_q;
          res_d.kind = grld_pkg::KIND_RUN;
          res_d.count = regions_q;
          res_d.distance = '0;
          res_d.unreached = 1'b0;
          res_d.label = '0;
          state_d = S_OUT;
        end
      end
      S_WK_CUR: begin
        cur_r_d = q_rdata[grld_pkg::ADDR_W-1:grld_pkg::COL_W];
        cur_c_d = q_rdata[grld_pkg::COL_W-1:0];
        cell_re = 1'b1;
        cell_raddr = q_rdata;
        state_d = S_WK_CV;
      end
      S_WK_CV: begin
        dist_d = cell_rdata.distance;
        lab_d = cell_rdata.label;
        k_d = '0;
        state_d = S_WK_NRD;
      end
      S_WK_NRD: begin
        if (nb_ok) begin
          cell_re = 1'b1;
          cell_raddr = nb_addr;
          state_d = S_WK_NEV;
        end else if (k_q == 3'd7) begin
          state_d = S_WK_POP;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_WK_NEV: begin
        if (!cell_rdata.reached) begin
          cell_we = 1'b1;
          cell_waddr = nb_addr;
          cell_wdata.reached = 1'b1;
          cell_wdata.distance = (dist_q == grld_pkg::DIST_SAT) ? dist_q : dist_q + 1'b1;
          cell_wdata.label = lab_q;
          if (q_room) begin
            q_we = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        if (k_q == 3'd7) begin
          state_d = S_WK_POP;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_WK_NRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      tail_q <= '0;
      regions_q <= '0;
      run_rows_q <= '0;
      run_cols_q <= '0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      tail_q <= tail_d;
      regions_q <= regions_d;
      run_rows_q <= run_rows_d;
      run_cols_q <= run_cols_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    r_q <= r_d;
    c_q <= c_d;
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    k_q <= k_d;
    lab_q <= lab_d;
    dist_q <= dist_d;
    rows_q <= rows_d;
    cols_q <= cols_d;
    res_q <= res_d;
  end

`ifndef ASSERT_OFF
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!cell_we && !q_we)) else $error("memory write while idle");
  a_run_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && req_valid_i && req_i.op == grld_pkg::OP_RUN) |=>
    (state_q == S_CLR_RD)) else $error("run did not start with clearing sweep");
`endif

endmodule
`default_nettype wire

@@ sim/grid_region_label_distance_unit_test.sv @@
`default_nettype none
module grid_region_label_distance_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  // unused command code, the block ignores it
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int NB_DR[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
  localparam int NB_DC[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [39:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [7:0]        cfg_data_i;

  grid_region_label_distance_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // grid mirror and walk state
  bit          occ_grid[grld_pkg::CELLS];
  bit          reach_grid[grld_pkg::CELLS];
  int          dist_grid[grld_pkg::CELLS];
  int          label_grid[grld_pkg::CELLS];
  int          walk_fifo[grld_pkg::CELLS];
  int          regions_seen;
  int          rows_reg, cols_reg;
  int          last_rows, last_cols;

  grld_pkg::req_t cmd_queue[$];
  grld_pkg::res_t answer_queue[$];
  bit          failed;
  bit          item_taken;
  bit          long_hold_req;
  int          burst_left, gap_left;
  int          hold_left, ready_mode, mode_left;

  function automatic int clamp_size(int v);
    if (v == 0) return 1;
    return (v > grld_pkg::MAX_ROWS) ? grld_pkg::MAX_ROWS : v;
  endfunction

  // region labelling followed by the multi-source chessboard walk
  task automatic run_grid();
    int rows, cols, head, tail, cur, nr, nc, n;
    rows = clamp_size(rows_reg);
    cols = clamp_size(cols_reg);
    for (int i = 0; i < grld_pkg::CELLS; i++) begin
      label_grid[i] = 0;
      dist_grid[i] = 0;
      reach_grid[i] = 0;
    end
    regions_seen = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (occ_grid[r*grld_pkg::MAX_COLS+c] && label_grid[r*grld_pkg::MAX_COLS+c] == 0) begin
          regions_seen++;
          label_grid[r*grld_pkg::MAX_COLS+c] = regions_seen;
          head = 0;
          tail = 1;
          walk_fifo[0] = r*grld_pkg::MAX_COLS + c;
          while (head < tail) begin
            cur = walk_fifo[head];
            head++;
            for (int k = 0; k < 8; k++) begin
              nr = cur / grld_pkg::MAX_COLS + NB_DR[k];
              nc = cur % grld_pkg::MAX_COLS + NB_DC[k];
              if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
              n = nr*grld_pkg::MAX_COLS + nc;
              if (occ_grid[n] && label_grid[n] == 0) begin
                label_grid[n] = regions_seen;
                walk_fifo[tail] = n;
                tail++;
              end
            end
          end
        end
      end
    end
    head = 0;
    tail = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (occ_grid[r*grld_pkg::MAX_COLS+c]) begin
          reach_grid[r*grld_pkg::MAX_COLS+c] = 1;
          walk_fifo[tail] = r*grld_pkg::MAX_COLS + c;
          tail++;
        end
      end
    end
    while (head < tail) begin
      cur = walk_fifo[head];
      head++;
      for (int k = 0; k < 8; k++) begin
        nr = cur / grld_pkg::MAX_COLS + NB_DR[k];
        nc = cur % grld_pkg::MAX_COLS + NB_DC[k];
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
        n = nr*grld_pkg::MAX_COLS + nc;
        if (!reach_grid[n]) begin
          reach_grid[n] = 1;
          dist_grid[n] = dist_grid[cur] + 1;
          label_grid[n] = label_grid[cur];
          walk_fifo[tail] = n;
          tail++;
        end
      end
    end
    last_rows = rows;
    last_cols = cols;
  endtask

  // expected answer for one accepted item
  task automatic predict_answer(grld_pkg::req_t it);
    grld_pkg::res_t e;
    int   idx;
    e = '0;
    idx = int'(it.row)*grld_pkg::MAX_COLS + int'(it.col);
    case (it.op)
      grld_pkg::OP_WRITE: occ_grid[idx] = (it.val < grld_pkg::OBSTACLE_LIMIT);
      grld_pkg::OP_RUN: begin
        run_grid();
        e.kind = grld_pkg::KIND_RUN;
        e.count = grld_pkg::LABEL_W'(regions_seen);
        answer_queue = {answer_queue, e};
      end
      grld_pkg::OP_READ: begin
        e.kind = grld_pkg::KIND_READ;
        e.count = grld_pkg::LABEL_W'(regions_seen);
        if (it.row < last_rows && it.col < last_cols && reach_grid[idx]) begin
          e.distance = (dist_grid[idx] > 127) ? grld_pkg::DIST_SAT :
                       grld_pkg::DIST_W'(dist_grid[idx]);
          e.label = grld_pkg::LABEL_W'(label_grid[idx]);
        end else begin
          e.unreached = 1'b1;
        end
        answer_queue = {answer_queue, e};
      end
      default: ;
    endcase
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // item sender, bursts with random gaps
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0 && rst_ni) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd_queue[0].op;
        s_axis_tdata <= {2'b00, cmd_queue[0].val, cmd_queue[0].col, cmd_queue[0].row};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk_i) begin
    if (mode_left <= 0) begin
      mode_left = $urandom_range(20, 120);
      ready_mode = $urandom_range(0, 2);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 4000;
      m_axis_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // accepted items feed the predictor; results are checked in order
  always @(posedge clk_i) begin
    grld_pkg::res_t e;
    grld_pkg::req_t taken;
    if (s_axis_tvalid && s_axis_tready) begin
      item_taken = 1'b1;
      taken = cmd_queue[0];
      cmd_queue.delete(0);
      predict_answer(taken);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (answer_queue.size() == 0) begin
        $error("result with nothing expected: tuser %0h tdata %0h", m_axis_tuser, m_axis_tdata);
        failed = 1'b1;
      end else begin
        e = answer_queue[0];
        answer_queue.delete(0);
        if (m_axis_tuser[0] !== e.kind) begin
          $error("result_kind expected %0d actual %0d", e.kind, m_axis_tuser[0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[12:0] !== e.count) begin
          $error("region_count expected %0d actual %0d", e.count, m_axis_tdata[12:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[19:13] !== e.distance) begin
          $error("distance expected %0d actual %0d", e.distance, m_axis_tdata[19:13]);
          failed = 1'b1;
        end
        if (m_axis_tdata[20] !== e.unreached) begin
          $error("unreached expected %0d actual %0d", e.unreached, m_axis_tdata[20]);
          failed = 1'b1;
        end
        if (m_axis_tdata[33:21] !== e.label) begin
          $error("region_label expected %0d actual %0d", e.label, m_axis_tdata[33:21]);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic queue_cmd(logic [1:0] op, int row, int col, int val);
    grld_pkg::req_t it;
    it.op = op;
    it.row = grld_pkg::ROW_W'(row);
    it.col = grld_pkg::COL_W'(col);
    it.val = grld_pkg::VAL_W'(val);
    cmd_queue = {cmd_queue, it};
  endtask

  // wait until the block is idle, then set a register
  task automatic set_reg(logic [0:0] idx, int val);
    wait (cmd_queue.size() == 0 && answer_queue.size() == 0);
    @(negedge clk_i);
    wait (!s_axis_tvalid);
    repeat (20) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 8'(val);
    if (idx == grld_pkg::REG_ROWS) rows_reg = val;
    else cols_reg = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // write every cell of the grid in use, obstacle share in percent
  task automatic fill_grid(int share);
    for (int r = 0; r < clamp_size(rows_reg); r++)
      for (int c = 0; c < clamp_size(cols_reg); c++)
        queue_cmd(grld_pkg::OP_WRITE, r, c, ($urandom_range(0, 99) < share) ?
                  $urandom_range(0, 127) : $urandom_range(128, 255));
  endtask

  // random mix of writes, reads, runs and ignored commands
  task automatic random_cmds(int count, int share);
    int rows, cols, pick, row, col;
    rows = clamp_size(rows_reg);
    cols = clamp_size(cols_reg);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
        row = $urandom_range(0, 127);
        col = $urandom_range(0, 127);
      end else begin
        row = $urandom_range(0, rows - 1);
        col = $urandom_range(0, cols - 1);
      end
      if (pick < 40) begin
        queue_cmd(grld_pkg::OP_WRITE, row, col, ($urandom_range(0, 99) < share) ?
                  $urandom_range(0, 127) : $urandom_range(128, 255));
      end else if (pick < 78) begin
        queue_cmd(grld_pkg::OP_READ, row, col, $urandom_range(0, 255));
      end else if (pick < 93) begin
        queue_cmd(grld_pkg::OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 255));
      end else begin
        queue_cmd(OP_IGNORED, row, col, $urandom_range(0, 255));
      end
    end
  endtask

  // stimulus
  initial begin
    int sizes[7][2];
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    failed = 1'b0;
    item_taken = 1'b0;
    long_hold_req = 1'b0;
    burst_left = 1;
    gap_left = 0;
    hold_left = 0;
    mode_left = 0;
    ready_mode = 0;
    rows_reg = 128;
    cols_reg = 128;
    last_rows = 0;
    last_cols = 0;
    regions_seen = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads before any run, ignored op, empty grid, corner obstacles
    set_reg(grld_pkg::REG_ROWS, 3);
    set_reg(grld_pkg::REG_COLS, 4);
    queue_cmd(grld_pkg::OP_READ, 0, 0, 0);
    queue_cmd(grld_pkg::OP_READ, 127, 127, 255);
    queue_cmd(OP_IGNORED, 127, 127, 255);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        queue_cmd(grld_pkg::OP_WRITE, r, c, (c[0]) ? 255 : 128);
    queue_cmd(grld_pkg::OP_RUN, 0, 0, 0);
    queue_cmd(grld_pkg::OP_READ, 1, 1, 0);
    queue_cmd(grld_pkg::OP_WRITE, 0, 0, 127);
    queue_cmd(grld_pkg::OP_WRITE, 2, 3, 0);
    queue_cmd(grld_pkg::OP_READ, 0, 0, 0);
    queue_cmd(grld_pkg::OP_RUN, 0, 0, 0);
    for (int c = 0; c < 4; c++) queue_cmd(grld_pkg::OP_READ, 1, c, 0);
    queue_cmd(grld_pkg::OP_READ, 2, 3, 0);
    queue_cmd(grld_pkg::OP_READ, 3, 0, 0);
    queue_cmd(grld_pkg::OP_WRITE, 127, 127, 0);
    queue_cmd(grld_pkg::OP_READ, 0, 2, 0);

    // register extremes and assorted small grids; zero acts as one, 255 as the maximum
    sizes = '{'{0, 0}, '{255, 1}, '{1, 128}, '{8, 8}, '{5, 12}, '{10, 7}, '{2, 2}};
    for (int p = 0; p < 7; p++) begin
      int share;
      share = $urandom_range(5, 60);
      set_reg(grld_pkg::REG_ROWS, sizes[p][0]);
      set_reg(grld_pkg::REG_COLS, sizes[p][1]);
      fill_grid(share);
      queue_cmd(grld_pkg::OP_RUN, 0, 0, 0);
      if (p == 3) long_hold_req = 1'b1;
      random_cmds(52, share);
    end

    wait (cmd_queue.size() == 0 && answer_queue.size() == 0);
    repeat (50) @(posedge clk_i);
    if (!failed && answer_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
